// File: hdl/ssm_pkg.sv
`default_nettype none

package ssm_pkg;

    // Width of one codepoint and of the pattern length register.
    localparam int CP_W = 21;
    localparam int LEN_W = 4;

    // The pattern registers: four words of three codepoints each.
    localparam int PAT_WORDS = 4;
    localparam int CPS_PER_WORD = 3;
    localparam int WORD_W = CP_W * CPS_PER_WORD;
    localparam int PAT_CAP = PAT_WORDS * CPS_PER_WORD;

    // Default for the longest pattern the block is built for.
    localparam int MAX_PATTERN_DEF = 12;

    // Configuration port.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_0 = 3'd1,
        REG_PATTERN_WORD_1 = 3'd2,
        REG_PATTERN_WORD_2 = 3'd3,
        REG_PATTERN_WORD_3 = 3'd4
    } ssm_reg_t;

    typedef logic [CP_W-1:0] cp_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [WORD_W-1:0] word_t;

    // Controls that reach each cell of the window chain.
    typedef struct packed {
        logic shift;     // an item is taken this cycle, the chain moves one place
        logic set_mark;  // a complete match was found on the moved window
        logic active;    // this cell lies inside the current pattern length
    } ssm_cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/substring_search_marker_top.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------------------------
// item     | item_valid / item_stall   | codepoint, line_end
// result   | result_valid / result_stall | out_codepoint, search_hit, out_line_end
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item is taken per cycle in steady state; its transfer and the result it
// releases happen in the same cycle, and the result waits in the output register.
// A line end, or a shortened pattern, releases the surplus one per cycle from the
// cell chain while the result side is not stalled; the item side stalls meanwhile.
// rst_n clears the configuration, the fill count, the marks and the output valid.
// A stalled result holds the output register and stalls the item side with it.
`default_nettype none

module substring_search_marker_top
    import ssm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  cp_t                  codepoint,
    input  logic                 line_end,

    output logic                 result_valid,
    input  logic                 result_stall,
    output cp_t                  out_codepoint,
    output logic                 search_hit,
    output logic                 out_line_end,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  word_t                cfg_data
);

    // The chain holds as many cells as the longest usable pattern.
    localparam int SLOTS  = (MAX_PATTERN < PAT_CAP) ? MAX_PATTERN : PAT_CAP;
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PAT_IDX_W = $clog2(PAT_CAP);

    typedef logic [FILL_W-1:0] fill_t;

    // Configuration registers live in their own block; writes are always taken.
    len_t len_eff;
    cp_t  pat_cps [PAT_CAP];

    assign cfg_ready = 1'b1;

    ssm_cfg #(
        .SLOTS(SLOTS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .len_eff  (len_eff),
        .pat_cps  (pat_cps)
    );

    // Control state: how many codepoints the chain holds, and whether the
    // chain is releasing surplus codepoints (drain) to the end of a line (flush).
    fill_t fill_reg, fill_next;
    logic  drain_reg, drain_next;
    logic  flush_reg, flush_next;

    logic  out_valid_reg, out_valid_next;
    cp_t   out_cp_reg;
    logic  out_hit_reg;
    logic  out_last_reg;

    logic  can_emit;
    logic  accept;
    logic  emit;
    logic  flush;
    logic  more;
    logic  hit;
    fill_t fill_work;
    fill_t fill_after;
    len_t  depth;
    logic [IDX_W-1:0] emit_idx;

    // Cell chain wiring.
    ssm_cell_ctrl_t cell_ctrl [SLOTS];
    cp_t  cp_held   [SLOTS];
    cp_t  cp_next   [SLOTS];
    cp_t  pat_al    [SLOTS];
    logic [PAT_IDX_W-1:0] pat_idx [SLOTS];
    logic [SLOTS-1:0] mark_held;
    logic [SLOTS-1:0] mark_next;
    logic [SLOTS-1:0] match_next;
    logic [SLOTS-1:0] in_pat;

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        // Cell k holds the k-th newest codepoint and compares it with pattern
        // position len-1-k, so the pattern reads oldest first along the chain.
        assign in_pat[k]  = (LEN_W'(k) < len_eff);
        assign pat_idx[k] = PAT_IDX_W'(len_eff - LEN_W'(k + 1));
        assign pat_al[k]  = in_pat[k] ? pat_cps[pat_idx[k]] : '0;

        assign cell_ctrl[k].shift    = accept;
        assign cell_ctrl[k].set_mark = accept & hit;
        assign cell_ctrl[k].active   = in_pat[k];

        if (k == 0)
        begin : g_head
            ssm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl[k]),
                .pat_cp    (pat_al[k]),
                .cp_in     (codepoint),
                .mark_in   (1'b0),
                .cp_held   (cp_held[k]),
                .mark_held (mark_held[k]),
                .cp_next   (cp_next[k]),
                .mark_next (mark_next[k]),
                .match_next(match_next[k])
            );
        end
        else
        begin : g_body
            ssm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl[k]),
                .pat_cp    (pat_al[k]),
                .cp_in     (cp_held[k-1]),
                .mark_in   (mark_held[k-1]),
                .cp_held   (cp_held[k]),
                .mark_held (mark_held[k]),
                .cp_next   (cp_next[k]),
                .mark_next (mark_next[k]),
                .match_next(match_next[k])
            );
        end
    end

    // The last cell's held values feed no neighbor; they are kept for symmetry
    // of the chain and folded in here so that every output is consumed.
    logic tail_unused;
    assign tail_unused = ^{cp_held[SLOTS-1], mark_held[SLOTS-1]};

    // The output register can load when it is empty or being emptied.
    assign can_emit   = !out_valid_reg || !result_stall;
    assign item_stall = drain_reg || !can_emit || (tail_unused & 1'b0);
    assign accept     = item_valid && !item_stall;

    // A pattern length of zero still releases each codepoint at once.
    assign depth = (len_eff == '0) ? LEN_W'(1) : len_eff;

    assign fill_work = accept ? (fill_reg + FILL_W'(1)) : fill_reg;

    // A match needs every cell inside the pattern length to agree with its
    // pattern codepoint and len codepoints of the current line in the chain.
    assign hit = (len_eff != '0) && (&(match_next | ~in_pat))
              && (LEN_W'(fill_work) >= len_eff);

    assign flush = accept ? line_end : flush_reg;

    assign emit = (accept && (line_end || (LEN_W'(fill_work) >= depth)))
               || (drain_reg && can_emit);

    assign fill_after = fill_work - FILL_W'(emit);
    assign emit_idx   = IDX_W'(fill_work - FILL_W'(1));

    // After this release, are more codepoints due before the next item?
    assign more = flush ? (fill_after != '0) : (LEN_W'(fill_after) >= depth);

    always_comb
    begin
        fill_next      = fill_after;
        drain_next     = drain_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (emit)
        begin
            drain_next     = more;
            flush_next     = more && flush;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            drain_reg     <= 1'b0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            drain_reg     <= drain_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The oldest held codepoint leaves with its mark as updated this cycle.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_cp_reg   <= cp_next[emit_idx];
            out_hit_reg  <= mark_next[emit_idx];
            out_last_reg <= flush && (fill_after == '0);
        end
    end

    assign result_valid  = out_valid_reg;
    assign out_codepoint = out_cp_reg;
    assign search_hit    = out_hit_reg;
    assign out_line_end  = out_last_reg;

endmodule

`default_nettype wire

// File: hdl/ssm_cfg.sv
`default_nettype none

module ssm_cfg
    import ssm_pkg::*;
#(
    parameter int SLOTS = PAT_CAP
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  word_t                cfg_data,
    output len_t                 len_eff,
    output cp_t                  pat_cps [PAT_CAP]
);

    len_t  pattern_length_reg;
    word_t pattern_word_reg [PAT_WORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            for (int w = 0; w < PAT_WORDS; w++)
            begin
                pattern_word_reg[w] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                REG_PATTERN_WORD_0: pattern_word_reg[0] <= cfg_data;
                REG_PATTERN_WORD_1: pattern_word_reg[1] <= cfg_data;
                REG_PATTERN_WORD_2: pattern_word_reg[2] <= cfg_data;
                REG_PATTERN_WORD_3: pattern_word_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A length beyond the number of cells acts as the number of cells.
    assign len_eff = (pattern_length_reg > LEN_W'(SLOTS)) ? LEN_W'(SLOTS)
                                                           : pattern_length_reg;

    for (genvar k = 0; k < PAT_CAP; k++)
    begin : g_unpack
        assign pat_cps[k] =
            pattern_word_reg[k / CPS_PER_WORD][(k % CPS_PER_WORD) * CP_W +: CP_W];
    end

endmodule

`default_nettype wire

// File: hdl/ssm_cell.sv
`default_nettype none

module ssm_cell
    import ssm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ssm_cell_ctrl_t ctrl,
    input  cp_t            pat_cp,
    input  cp_t            cp_in,
    input  logic           mark_in,
    output cp_t            cp_held,
    output logic           mark_held,
    output cp_t            cp_next,
    output logic           mark_next,
    output logic           match_next
);

    // cp_reg is the window slot of this cell's age; pat_cp is the pattern
    // codepoint that lines up with this slot under the current length.
    cp_t  cp_reg;
    logic mark_reg;

    assign cp_next    = ctrl.shift ? cp_in : cp_reg;
    assign mark_next  = (ctrl.shift ? mark_in : mark_reg) | (ctrl.set_mark & ctrl.active);
    assign match_next = (cp_next == pat_cp);

    always_ff @(posedge clk)
    begin
        cp_reg <= cp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    assign cp_held   = cp_reg;
    assign mark_held = mark_reg;

endmodule

`default_nettype wire

// File: hdl/ssm_checker.sv
`default_nettype none

module ssm_checker
    import ssm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_stall,
    input logic line_end,
    input logic result_valid,
    input logic result_stall,
    input cp_t  out_codepoint,
    input logic search_hit,
    input logic out_line_end
);

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(out_codepoint) && $stable(search_hit) && $stable(out_line_end))
        else $error("result payload changed while stalled");

    // No item is taken while the result side is blocked.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("item transfer while result stalled");

    // A line end always releases a result; either it closes the line at once
    // or the block stalls items while it releases the rest.
    a_line_flush: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && line_end |=>
            result_valid && (item_stall || out_line_end))
        else $error("line end did not flush");

endmodule

bind substring_search_marker_top ssm_checker u_ssm_checker (.*);

`default_nettype wire
